>>> rtl/tcct_pkg.sv
// Shared types and constants for the trilinear color cube texel block.
// Used by every module under rtl; depends on nothing else.
package tcct_pkg;

    // Field and register widths
    localparam int COORD_W      = 6;
    localparam int IDX_W        = 18;
    localparam int CHAN_W       = 8;
    localparam int NUM_CHAN     = 4;
    localparam int WORD_W       = NUM_CHAN * CHAN_W;
    localparam int CORNER_REG_W = 2 * WORD_W;
    localparam int NUM_CORNER_REGS = 4;
    localparam int NUM_AXES     = 3;
    localparam int DIM_REG_W    = 7;
    localparam int CFG_IDX_W    = 3;

    // Weights are unsigned Q1.16, so one integer bit over sixteen fraction bits.
    localparam int FRAC_W       = 16;
    localparam int WEIGHT_W     = FRAC_W + 1;

    // Quotient bits resolved per divider stage in the front end.
    localparam int STEP_BITS    = 4;

    // Depth of the queue between the front end and the blend pipeline.
    localparam int QUEUE_DEPTH  = 4;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 56;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 7'd16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRONT_BOTTOM = 3'd0,
        REG_FRONT_TOP    = 3'd1,
        REG_BACK_BOTTOM  = 3'd2,
        REG_BACK_TOP     = 3'd3,
        REG_GRID_WIDTH   = 3'd4,
        REG_GRID_HEIGHT  = 3'd5,
        REG_GRID_DEPTH   = 3'd6
    } t_reg_idx;

    // Current configuration as seen by the front end and the blend pipeline.
    typedef struct packed {
        logic [NUM_CORNER_REGS-1:0][CORNER_REG_W-1:0] corners;
        logic [NUM_AXES-1:0][DIM_REG_W-1:0]           dims;
    } t_cfg;

    // One classified texel handed from the front end to the blend pipeline.
    // weight[0] is x, weight[1] is y, weight[2] is z.
    typedef struct packed {
        logic [IDX_W-1:0]                   index;
        logic [NUM_AXES-1:0][WEIGHT_W-1:0]  weight;
    } t_item;

endpackage

>>> rtl/trilinear_color_cube_texel.sv
// An accepted input beat passes 5 front stages, a queue slot and 6 blend stages
// before its result beat is valid. Throughput: one beat per cycle without stalls.
// The 4-entry queue lets the front keep taking beats while the output stalls.
// Reset (synchronous, active low) clears all valid bits and the queue, sets the
// corner registers to zero and the grid dimensions to 16; no clearing pass.
module trilinear_color_cube_texel #(
    parameter int MAX_DIM = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [tcct_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcct_pkg::CORNER_REG_W-1:0]   i_cfg_data,
    // Input beats
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: coord_x [5:0], coord_y [11:6], coord_z [17:12], zero [23:18]
    input  logic [tcct_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Result beats
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: texel_index [17:0], red [25:18], green [33:26], blue [41:34],
    //        alpha [49:42], zero [55:50]
    output logic [tcct_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int COORD_W = tcct_pkg::COORD_W;
    localparam int IDX_W   = tcct_pkg::IDX_W;
    localparam int PAD_W   = tcct_pkg::OUT_DATA_W - IDX_W
                           - tcct_pkg::NUM_CHAN * tcct_pkg::CHAN_W;

    tcct_pkg::t_cfg   r_cfg;
    tcct_pkg::t_item  front_item, queue_item;
    logic             front_valid, queue_in_ready;
    logic             queue_valid, back_ready;
    logic [IDX_W-1:0] back_index;
    logic [tcct_pkg::NUM_CHAN-1:0][tcct_pkg::CHAN_W-1:0] back_chan;

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.corners <= '0;
            r_cfg.dims    <= {tcct_pkg::NUM_AXES{tcct_pkg::DIM_RESET}};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tcct_pkg::REG_FRONT_BOTTOM: r_cfg.corners[0] <= i_cfg_data;
                tcct_pkg::REG_FRONT_TOP:    r_cfg.corners[1] <= i_cfg_data;
                tcct_pkg::REG_BACK_BOTTOM:  r_cfg.corners[2] <= i_cfg_data;
                tcct_pkg::REG_BACK_TOP:     r_cfg.corners[3] <= i_cfg_data;
                tcct_pkg::REG_GRID_WIDTH:
                    r_cfg.dims[0] <= i_cfg_data[tcct_pkg::DIM_REG_W-1:0];
                tcct_pkg::REG_GRID_HEIGHT:
                    r_cfg.dims[1] <= i_cfg_data[tcct_pkg::DIM_REG_W-1:0];
                tcct_pkg::REG_GRID_DEPTH:
                    r_cfg.dims[2] <= i_cfg_data[tcct_pkg::DIM_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Coordinate clamping, index and weights
    tcct_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_x       (s_axis_tdata[COORD_W-1:0]),
        .i_y       (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_z       (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
        .o_valid   (front_valid),
        .o_item    (front_item),
        .i_q_ready (queue_in_ready)
    );

    // Decoupling queue
    tcct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (queue_in_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_ready (back_ready),
        .o_item  (queue_item)
    );

    // Color blending and output register
    tcct_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (queue_valid),
        .o_ready (back_ready),
        .i_item  (queue_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_index (back_index),
        .o_chan  (back_chan)
    );

    assign m_axis_tdata = {PAD_W'(0), back_chan, back_index};

endmodule

>>> rtl/tcct_front.sv
// Front end: accepts coordinate beats, clamps them, computes the linear texel
// index and the three Q1.16 axis weights through a pipelined divider.
// Depends on tcct_pkg.
module tcct_front #(
    parameter int MAX_DIM = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcct_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tcct_pkg::COORD_W-1:0]  i_x,
    input  logic [tcct_pkg::COORD_W-1:0]  i_y,
    input  logic [tcct_pkg::COORD_W-1:0]  i_z,
    output logic                          o_valid,
    output tcct_pkg::t_item               o_item,
    input  logic                          i_q_ready
);

    localparam int COORD_W   = tcct_pkg::COORD_W;
    localparam int IDX_W     = tcct_pkg::IDX_W;
    localparam int FRAC_W    = tcct_pkg::FRAC_W;
    localparam int STEP_BITS = tcct_pkg::STEP_BITS;
    localparam int NUM_AXES  = tcct_pkg::NUM_AXES;
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int CW = (DIM_W > tcct_pkg::DIM_REG_W) ? DIM_W : tcct_pkg::DIM_REG_W;
    localparam int KW = (DIM_W > COORD_W) ? DIM_W : COORD_W;
    // One stage for clamping, then the divider stages.
    localparam int NSTG      = 1 + FRAC_W / STEP_BITS;
    localparam int LAST      = NSTG - 1;

    // Several restoring division steps on a remainder that stays below the divisor.
    function automatic logic [DIM_W+STEP_BITS-1:0] div_step(
        input logic [DIM_W-1:0] rem,
        input logic [DIM_W-1:0] dvs
    );
        logic [DIM_W:0]         r2;
        logic [DIM_W-1:0]       r;
        logic [STEP_BITS-1:0]   q;
        r = rem;
        q = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--) begin
            r2 = {r, 1'b0};
            if ((dvs != '0) && (r2 >= {1'b0, dvs})) begin
                q[i] = 1'b1;
                r2   = r2 - {1'b0, dvs};
            end
            r = r2[DIM_W-1:0];
        end
        return {r, q};
    endfunction

    logic                  f_adv;
    logic [DIM_W-1:0]      eff [NUM_AXES];
    logic [DIM_W-1:0]      dv [NUM_AXES];
    logic [COORD_W-1:0]    coord_in [NUM_AXES];
    logic [COORD_W-1:0]    clamped [NUM_AXES];
    logic [NUM_AXES-1:0]   int_in;
    logic [DIM_W-1:0]      rem_in [NUM_AXES];

    logic [NSTG-1:0]       r_v;
    logic [NUM_AXES-1:0]   r_int [NSTG];
    logic [DIM_W-1:0]      r_rem [NSTG][NUM_AXES];
    logic [FRAC_W-1:0]     r_frac [NSTG][NUM_AXES];
    logic [DIM_W-1:0]      n_rem [1:LAST][NUM_AXES];
    logic [FRAC_W-1:0]     n_frac [1:LAST][NUM_AXES];

    logic [COORD_W-1:0]    r_x0, r_y0, r_z0, r_x1, r_z1;
    logic [IDX_W-1:0]      r_yw, r_hw, r_xyw, r_zhw, r_idx3, r_idx4;

    // The whole front pipeline moves unless its last stage waits on a full queue.
    assign f_adv   = !r_v[LAST] || i_q_ready;
    assign o_ready = f_adv;
    assign o_valid = r_v[LAST];

    assign coord_in[0] = i_x;
    assign coord_in[1] = i_y;
    assign coord_in[2] = i_z;

    // Effective dimensions: zero counts as one, anything above MAX_DIM saturates.
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (i_cfg.dims[a] == '0) begin
                eff[a] = DIM_W'(1);
            end else if (CW'(i_cfg.dims[a]) > CW'(MAX_DIM)) begin
                eff[a] = DIM_W'(MAX_DIM);
            end else begin
                eff[a] = DIM_W'(i_cfg.dims[a]);
            end
            dv[a] = eff[a] - DIM_W'(1);
        end
    end

    // Clamp each coordinate and set up the division coord * 65536 / (dim - 1).
    // A clamped coordinate never exceeds the divisor, so the integer bit is set
    // only at the far edge, where the fraction is zero. A one-texel axis keeps
    // everything at zero.
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (KW'(coord_in[a]) > KW'(dv[a])) begin
                clamped[a] = COORD_W'(dv[a]);
            end else begin
                clamped[a] = coord_in[a];
            end
            int_in[a] = (dv[a] != '0) && (KW'(clamped[a]) == KW'(dv[a]));
            rem_in[a] = int_in[a] ? '0 : DIM_W'(clamped[a]);
        end
    end

    // Divider stages: each one resolves STEP_BITS fraction bits per axis.
    always_comb begin
        logic [DIM_W+STEP_BITS-1:0] res;
        for (int s = 1; s < NSTG; s++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                res          = div_step(r_rem[s-1][a], dv[a]);
                n_rem[s][a]  = res[DIM_W+STEP_BITS-1:STEP_BITS];
                n_frac[s][a] = {r_frac[s-1][a][FRAC_W-STEP_BITS-1:0], res[STEP_BITS-1:0]};
            end
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (f_adv) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    // Divider payload
    always_ff @(posedge i_clk) begin
        if (f_adv) begin
            r_int[0] <= int_in;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_rem[0][a]  <= rem_in[a];
                r_frac[0][a] <= '0;
            end
            for (int s = 1; s < NSTG; s++) begin
                r_int[s] <= r_int[s-1];
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_rem[s][a]  <= n_rem[s][a];
                    r_frac[s][a] <= n_frac[s][a];
                end
            end
        end
    end

    // Linear index x + y*w + z*h*w, kept to its low bits, alongside the divider.
    always_ff @(posedge i_clk) begin
        if (f_adv) begin
            r_x0   <= clamped[0];
            r_y0   <= clamped[1];
            r_z0   <= clamped[2];
            r_yw   <= IDX_W'(r_y0) * IDX_W'(eff[0]);
            r_hw   <= IDX_W'(eff[1]) * IDX_W'(eff[0]);
            r_x1   <= r_x0;
            r_z1   <= r_z0;
            r_xyw  <= IDX_W'(r_x1) + r_yw;
            r_zhw  <= IDX_W'(r_z1) * r_hw;
            r_idx3 <= r_xyw + r_zhw;
            r_idx4 <= r_idx3;
        end
    end

    // Hand-off item
    always_comb begin
        o_item.index = r_idx4;
        for (int a = 0; a < NUM_AXES; a++) begin
            o_item.weight[a] = {r_int[LAST][a], r_frac[LAST][a]};
        end
    end

    // A weight of one carries no fraction bits.
    a_weight_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] |-> (!(r_int[LAST][0] && (r_frac[LAST][0] != '0)) &&
                       !(r_int[LAST][1] && (r_frac[LAST][1] != '0)) &&
                       !(r_int[LAST][2] && (r_frac[LAST][2] != '0))))
        else $error("front: weight above one");

    // The divider remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] |-> ((dv[0] == '0 || r_rem[LAST][0] < dv[0]) &&
                       (dv[1] == '0 || r_rem[LAST][1] < dv[1]) &&
                       (dv[2] == '0 || r_rem[LAST][2] < dv[2])))
        else $error("front: divider remainder out of range");

endmodule

>>> rtl/tcct_queue.sv
// Short queue that decouples the front end from the blend pipeline.
// Depends on tcct_pkg.
module tcct_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tcct_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output tcct_pkg::t_item o_item
);

    localparam int DEPTH = tcct_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcct_pkg::t_item   r_slot [DEPTH];
    logic [PW-1:0]     r_wptr, r_rptr;
    logic [CNT_W-1:0]  r_count;
    logic              push, pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_slot[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue: fill count above depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue: push not counted");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("queue: pop not counted");

endmodule

>>> rtl/tcct_back.sv
// Blend pipeline: three exact lerps (x, y, then z) per channel over the eight
// corner colors, truncated to 8 bits, with an output register. Depends on tcct_pkg.
module tcct_back (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  tcct_pkg::t_cfg                                     i_cfg,
    input  logic                                               i_valid,
    output logic                                               o_ready,
    input  tcct_pkg::t_item                                    i_item,
    output logic                                               o_valid,
    input  logic                                               i_ready,
    output logic [tcct_pkg::IDX_W-1:0]                         o_index,
    output logic [tcct_pkg::NUM_CHAN-1:0][tcct_pkg::CHAN_W-1:0] o_chan
);

    localparam int CHAN_W   = tcct_pkg::CHAN_W;
    localparam int NUM_CHAN = tcct_pkg::NUM_CHAN;
    localparam int WORD_W   = tcct_pkg::WORD_W;
    localparam int FRAC_W   = tcct_pkg::FRAC_W;
    localparam int WEIGHT_W = tcct_pkg::WEIGHT_W;
    localparam int IDX_W    = tcct_pkg::IDX_W;
    localparam int NUM_GRP  = tcct_pkg::NUM_CORNER_REGS;
    localparam int NUM_ROW  = NUM_GRP / 2;
    // Exact intermediate widths after each lerp
    localparam int AX_W     = CHAN_W + FRAC_W;
    localparam int AY_W     = AX_W + FRAC_W;
    localparam int SUM_W    = AY_W + FRAC_W;
    localparam int PX_W     = (CHAN_W + 1) + (WEIGHT_W + 1);
    localparam int PY_W     = (AX_W + 1) + (WEIGHT_W + 1);
    // The z difference is split so that neither z product exceeds 21 by 18 bits.
    localparam int SPLIT    = 20;
    localparam int HI_W     = AY_W + 1 - SPLIT;
    localparam int PHI_W    = HI_W + WEIGHT_W + 1;
    localparam int PLO_W    = SPLIT + WEIGHT_W;
    localparam int NSTG     = 6;

    logic                         b_adv;
    logic [NSTG-1:0]              r_v;

    logic signed [PX_W-1:0]       n_px [NUM_CHAN][NUM_GRP];
    logic signed [PY_W-1:0]       n_py [NUM_CHAN][NUM_ROW];
    logic signed [PHI_W-1:0]      n_phi [NUM_CHAN];
    logic [PLO_W-1:0]             n_plo [NUM_CHAN];
    logic [SUM_W-1:0]             chan_sum [NUM_CHAN];

    logic [CHAN_W-1:0]            r_a0 [NUM_CHAN][NUM_GRP];
    logic signed [PX_W-1:0]       r_px [NUM_CHAN][NUM_GRP];
    logic [AX_W-1:0]              r_ax [NUM_CHAN][NUM_GRP];
    logic [AX_W-1:0]              r_ax0 [NUM_CHAN][NUM_ROW];
    logic signed [PY_W-1:0]       r_py [NUM_CHAN][NUM_ROW];
    logic [AY_W-1:0]              r_ay [NUM_CHAN][NUM_ROW];
    logic [AY_W-1:0]              r_ay0 [NUM_CHAN];
    logic signed [PHI_W-1:0]      r_phi [NUM_CHAN];
    logic [PLO_W-1:0]             r_plo [NUM_CHAN];
    logic [CHAN_W-1:0]            r_chan [NUM_CHAN];

    logic [WEIGHT_W-1:0]          r_wy0, r_wy1, r_wz0, r_wz1, r_wz2, r_wz3;
    logic [IDX_W-1:0]             r_idx0, r_idx1, r_idx2, r_idx3, r_idx4, r_idx5;

    // The pipeline moves unless the output register holds an untaken beat.
    assign b_adv   = !r_v[NSTG-1] || i_ready;
    assign o_ready = b_adv;
    assign o_valid = r_v[NSTG-1];
    assign o_index = r_idx5;

    always_comb begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            o_chan[ch] = r_chan[ch];
        end
    end

    // Each lerp is a*65536 + (b - a)*w, which equals a*(65536 - w) + b*w.
    always_comb begin
        logic signed [CHAN_W:0] dx;
        logic signed [AX_W:0]   dy;
        logic signed [AY_W:0]   dz;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            // x products: right minus left corner of each register
            for (int g = 0; g < NUM_GRP; g++) begin
                dx = $signed({1'b0, i_cfg.corners[g][WORD_W + ch*CHAN_W +: CHAN_W]})
                   - $signed({1'b0, i_cfg.corners[g][ch*CHAN_W +: CHAN_W]});
                n_px[ch][g] = dx * $signed({1'b0, i_item.weight[0]});
            end
            // y products: top minus bottom
            for (int k = 0; k < NUM_ROW; k++) begin
                dy = $signed({1'b0, r_ax[ch][2*k+1]}) - $signed({1'b0, r_ax[ch][2*k]});
                n_py[ch][k] = dy * $signed({1'b0, r_wy1});
            end
            // z products: back minus front, in a high and a low part
            dz = $signed({1'b0, r_ay[ch][1]}) - $signed({1'b0, r_ay[ch][0]});
            n_phi[ch] = $signed(dz[AY_W:SPLIT]) * $signed({1'b0, r_wz3});
            n_plo[ch] = dz[SPLIT-1:0] * r_wz3;
            // Final sum; the true value lies below 2^56 so wrapping is harmless.
            chan_sum[ch] = {r_ay0[ch], FRAC_W'(0)}
                         + {r_phi[ch][SUM_W-SPLIT-1:0], SPLIT'(0)}
                         + SUM_W'(r_plo[ch]);
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (b_adv) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    // Blend payload
    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            for (int ch = 0; ch < NUM_CHAN; ch++) begin
                for (int g = 0; g < NUM_GRP; g++) begin
                    r_a0[ch][g] <= i_cfg.corners[g][ch*CHAN_W +: CHAN_W];
                    r_px[ch][g] <= n_px[ch][g];
                    r_ax[ch][g] <= {r_a0[ch][g], FRAC_W'(0)} + r_px[ch][g][AX_W-1:0];
                end
                for (int k = 0; k < NUM_ROW; k++) begin
                    r_ax0[ch][k] <= r_ax[ch][2*k];
                    r_py[ch][k]  <= n_py[ch][k];
                    r_ay[ch][k]  <= {r_ax0[ch][k], FRAC_W'(0)} + r_py[ch][k][AY_W-1:0];
                end
                r_ay0[ch]  <= r_ay[ch][0];
                r_phi[ch]  <= n_phi[ch];
                r_plo[ch]  <= n_plo[ch];
                r_chan[ch] <= chan_sum[ch][SUM_W-1 -: CHAN_W];
            end
            r_wy0  <= i_item.weight[1];
            r_wz0  <= i_item.weight[2];
            r_wy1  <= r_wy0;
            r_wz1  <= r_wz0;
            r_wz2  <= r_wz1;
            r_wz3  <= r_wz2;
            r_idx0 <= i_item.index;
            r_idx1 <= r_idx0;
            r_idx2 <= r_idx1;
            r_idx3 <= r_idx2;
            r_idx4 <= r_idx3;
            r_idx5 <= r_idx4;
        end
    end

    // Nothing leaves the queue while a finished beat waits at the output.
    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTG-1] && !i_ready) |-> !(i_valid && o_ready))
        else $error("back: queue popped while output stalled");

endmodule
